FILE: rtl/per_key_amount_aggregator_top_assert.svh
// Assertion macros for the aggregator.
`ifndef PER_KEY_AMOUNT_AGGREGATOR_TOP_ASSERT_SVH
`define PER_KEY_AMOUNT_AGGREGATOR_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AGG_CHK(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error("aggregator check failed");
`define AGG_CHK_NEXT(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error("aggregator check failed");
`else
`define AGG_CHK(lbl, ant, con)
`define AGG_CHK_NEXT(lbl, ant, con)
`endif
`endif

FILE: rtl/pkaa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pkaa_pkg;
	localparam int CAPACITY = 32;
	localparam int AW       = $clog2(CAPACITY);
	localparam int CW       = 6;
	localparam int KEY_W    = 520;
	localparam int SUM_W    = 32;
	localparam int ENT_W    = KEY_W + SUM_W;
	localparam int ORD_W    = 8 + AW;

	typedef enum logic [1:0] {
		ROW_OWNER  = 2'd0,
		ROW_TOTAL  = 2'd1,
		ROW_REJECT = 2'd2
	} row_kind_t;

	typedef enum logic [0:0] {
		MODE_ADD    = 1'b0,
		MODE_REPORT = 1'b1
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPD,
		ST_INS,
		ST_REJ,
		ST_RSCAN,
		ST_RREAD,
		ST_RROW,
		ST_TOTAL
	} state_t;
endpackage
`default_nettype wire

FILE: rtl/per_key_amount_aggregator_top.sv
// Group-by-sum table over 65-byte keys, up to 32 entries.
// Input channel s_axis: tuser is the mode (0 add, 1 report), tdata the key and amount.
// Output channel m_axis: tuser is the row kind, tlast marks the last row of an item.
// Add: the key is compared against stored entries, one per cycle from the table
// memory. A hit updates the sum, a miss inserts; a miss on a full table
// yields one reject row.
// Report: a selection pass over the memory finds each next row in order
// (first byte ascending, newest first); a total row follows the last row,
// and the table is emptied.
// One item is worked on at a time; s_axis_tready is high only when idle.
// A registered output word holds a row while the receiver stalls; the block
// pauses on the next row until that word is taken.
// Reset empties the table at once (entry count cleared); no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "per_key_amount_aggregator_top_assert.svh"
module per_key_amount_aggregator_top import pkaa_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	// key_first_byte[7:0], key_rest_0..7 (64 each), add_amount[31:0]
	input  wire logic [ENT_W-1:0] s_axis_tdata,
	// mode
	input  wire logic [0:0]       s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	// out_first_byte[7:0], out_rest_0..7 (64 each), sum_value[31:0]
	output logic [ENT_W-1:0]      m_axis_tdata,
	// row_kind[1:0]
	output logic [1:0]            m_axis_tuser,
	output logic                  m_axis_tlast
);
	logic [ENT_W-1:0] mem [CAPACITY];
	logic [ENT_W-1:0] rd_q;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic             we;
	logic [AW-1:0]    wr_addr;
	logic [ENT_W-1:0] wr_data;

	state_t           state_q, state_d;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    ptr_q;
	logic             vld_s1;
	logic [AW-1:0]    idx_s1;
	logic [ENT_W-1:0] item_q;
	logic [AW-1:0]    idx_q;
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] total_q;
	logic             best_vld_q, have_prev_q;
	logic [AW-1:0]    best_idx_q;
	logic [ORD_W-1:0] best_ord_q, prev_ord_q;

	logic             accept, issue, hit, scan_done, out_free, out_load;
	logic [ORD_W-1:0] ord;
	logic             better;
	logic [ENT_W-1:0] out_data_d;
	logic [1:0]       out_kind_d;
	logic             out_last_d;

	assign accept    = s_axis_tvalid && s_axis_tready;
	assign issue     = (ptr_q < cnt_q);
	assign hit       = vld_s1 && (rd_q[KEY_W-1:0] == item_q[KEY_W-1:0]);
	assign scan_done = !issue && !vld_s1;
	assign out_free  = !m_axis_tvalid || m_axis_tready;
	// order key: first byte, then inverted index so newer entries come first
	assign ord       = {rd_q[7:0], ~idx_s1};
	assign better    = vld_s1 && (!have_prev_q || ord > prev_ord_q) &&
	                   (!best_vld_q || ord < best_ord_q);

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		rd_en         = 1'b0;
		rd_addr       = ptr_q[AW-1:0];
		we            = 1'b0;
		wr_addr       = idx_q;
		wr_data       = {sum_q, item_q[KEY_W-1:0]};
		out_load      = 1'b0;
		out_data_d    = '0;
		out_kind_d    = ROW_OWNER;
		out_last_d    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = (s_axis_tuser == MODE_REPORT) ? ST_RSCAN : ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en = issue && !hit;
				if (hit) begin
					state_d = ST_UPD;
				end else if (scan_done) begin
					state_d = (cnt_q >= CW'(CAPACITY)) ? ST_REJ : ST_INS;
				end
			end
			ST_UPD: begin
				we      = 1'b1;
				state_d = ST_IDLE;
			end
			ST_INS: begin
				we      = 1'b1;
				wr_addr = cnt_q[AW-1:0];
				wr_data = item_q;
				state_d = ST_IDLE;
			end
			ST_REJ: begin
				out_kind_d = ROW_REJECT;
				out_last_d = 1'b1;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_RSCAN: begin
				rd_en = issue;
				if (scan_done) begin
					state_d = best_vld_q ? ST_RREAD : ST_TOTAL;
				end
			end
			ST_RREAD: begin
				rd_en   = 1'b1;
				rd_addr = best_idx_q;
				state_d = ST_RROW;
			end
			ST_RROW: begin
				out_data_d = rd_q;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_RSCAN;
				end
			end
			ST_TOTAL: begin
				out_kind_d = ROW_TOTAL;
				out_last_d = 1'b1;
				out_data_d = {total_q, {KEY_W{1'b0}}};
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			ptr_q         <= '0;
			vld_s1        <= 1'b0;
			best_vld_q    <= 1'b0;
			have_prev_q   <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					ptr_q       <= '0;
					vld_s1      <= 1'b0;
					best_vld_q  <= 1'b0;
					have_prev_q <= 1'b0;
				end
				ST_SCAN: begin
					ptr_q  <= ptr_q + CW'(rd_en);
					vld_s1 <= rd_en;
				end
				ST_RSCAN: begin
					ptr_q  <= ptr_q + CW'(rd_en);
					vld_s1 <= rd_en;
					if (better) begin
						best_vld_q <= 1'b1;
					end
				end
				ST_INS: cnt_q <= cnt_q + CW'(1);
				ST_RROW: begin
					if (out_free) begin
						have_prev_q <= 1'b1;
						best_vld_q  <= 1'b0;
						ptr_q       <= '0;
						vld_s1      <= 1'b0;
					end
				end
				ST_TOTAL: begin
					if (out_free) begin
						cnt_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q  <= s_axis_tdata;
			total_q <= '0;
		end
		if (state_q == ST_SCAN || state_q == ST_RSCAN) begin
			idx_s1 <= ptr_q[AW-1:0];
		end
		if (state_q == ST_SCAN && hit) begin
			idx_q <= idx_s1;
			sum_q <= rd_q[ENT_W-1:KEY_W] + item_q[ENT_W-1:KEY_W];
		end
		if (state_q == ST_RSCAN && better) begin
			best_idx_q <= idx_s1;
			best_ord_q <= ord;
		end
		if (state_q == ST_RROW && out_free) begin
			prev_ord_q <= best_ord_q;
			total_q    <= total_q + rd_q[ENT_W-1:KEY_W];
		end
		if (out_load) begin
			m_axis_tdata <= out_data_d;
			m_axis_tuser <= out_kind_d;
			m_axis_tlast <= out_last_d;
		end
	end

	`AGG_CHK(a_cnt_bound, 1'b1, cnt_q <= CW'(CAPACITY))
	`AGG_CHK_NEXT(a_clear, state_q == ST_TOTAL && out_free, cnt_q == '0 && state_q == ST_IDLE)
	`AGG_CHK(a_owner_not_last, m_axis_tvalid && m_axis_tuser == ROW_OWNER, !m_axis_tlast)
	`AGG_CHK_NEXT(a_reject_full, state_q == ST_REJ, cnt_q == CW'(CAPACITY))

endmodule
`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import pkaa_pkg::*;

	typedef struct packed {
		row_kind_t        kind;
		logic [ENT_W-1:0] data;
		logic             last;
	} row_t;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	// key_first_byte[7:0], key_rest_0..7 (64 each), add_amount[31:0]
	logic [ENT_W-1:0] s_axis_tdata;
	// mode
	logic [0:0]       s_axis_tuser;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	// out_first_byte[7:0], out_rest_0..7 (64 each), sum_value[31:0]
	logic [ENT_W-1:0] m_axis_tdata;
	// row_kind[1:0]
	logic [1:0]       m_axis_tuser;
	logic             m_axis_tlast;

	per_key_amount_aggregator_top dut (.*);

	// predictor state
	logic [KEY_W-1:0] tbl_key [CAPACITY];
	logic [SUM_W-1:0] tbl_sum [CAPACITY];
	int               tbl_count;
	row_t             rows_due[$];
	logic [KEY_W-1:0] key_pool[$];
	int               errors, n_adds, n_reports, n_rejects, n_rows;
	bit               no_gaps;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#15000000;
		$display("Verification failed");
		$finish;
	end

	function automatic void predict_item(mode_t mode, logic [ENT_W-1:0] d);
		logic [KEY_W-1:0] key;
		logic [SUM_W-1:0] total;
		row_t             r;
		key = d[KEY_W-1:0];
		if (mode == MODE_ADD) begin
			n_adds++;
			for (int i = 0; i < tbl_count; i++) begin
				if (tbl_key[i] == key) begin
					tbl_sum[i] += d[ENT_W-1 -: SUM_W];
					return;
				end
			end
			if (tbl_count >= CAPACITY) begin
				n_rejects++;
				r.kind = ROW_REJECT;
				r.data = '0;
				r.last = 1'b1;
				rows_due.push_back(r);
				return;
			end
			tbl_key[tbl_count] = key;
			tbl_sum[tbl_count] = d[ENT_W-1 -: SUM_W];
			tbl_count++;
		end else begin
			n_reports++;
			total = '0;
			// ascending first byte, newest first within a byte
			for (int b = 0; b < 256; b++) begin
				for (int i = tbl_count - 1; i >= 0; i--) begin
					if (tbl_key[i][7:0] == b[7:0]) begin
						r.kind = ROW_OWNER;
						r.data = {tbl_sum[i], tbl_key[i]};
						r.last = 1'b0;
						rows_due.push_back(r);
						total += tbl_sum[i];
					end
				end
			end
			r.kind = ROW_TOTAL;
			r.data = {total, {KEY_W{1'b0}}};
			r.last = 1'b1;
			rows_due.push_back(r);
			tbl_count = 0;
		end
	endfunction

	task automatic send_item(mode_t mode, logic [ENT_W-1:0] d);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= d;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		predict_item(mode, d);
	endtask

	function automatic logic [KEY_W-1:0] rand_key(logic [7:0] fb);
		logic [KEY_W-1:0] k;
		for (int w = 0; w < 8; w++)
			k[8 + 64*w +: 64] = {$urandom, $urandom};
		k[7:0] = fb;
		return k;
	endfunction

	task automatic add_key(logic [KEY_W-1:0] key, logic [SUM_W-1:0] amt);
		send_item(MODE_ADD, {amt, key});
	endtask

	task automatic report_all();
		send_item(MODE_REPORT, {$urandom, rand_key(8'($urandom))});
	endtask

	// block may still be scanning after the last row; allow for a full lookup
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (rows_due.size() != 0) @(posedge clk);
		repeat (CAPACITY + 10) @(posedge clk);
	endtask

	task automatic test_empty_report();
		report_all();
		report_all();
	endtask

	task automatic test_extremes();
		logic [KEY_W-1:0] k0, k1;
		k0 = '0;
		k1 = '1;
		no_gaps = 1'b1;
		add_key(k0, 32'hFFFF_FFFF);
		add_key(k1, 32'h0);
		add_key(k0, 32'h2);            // wraps
		add_key(k1, 32'hFFFF_FFFF);
		no_gaps = 1'b0;
		// same first byte, ordering newest first
		add_key(rand_key(8'h80), 32'h1);
		add_key(rand_key(8'h80), 32'h2);
		add_key({k1[KEY_W-1:8], 8'h00}, 32'h8000_0000);
		add_key({k0[KEY_W-1:8], 8'hFF}, 32'h8000_0000);
		report_all();
	endtask

	task automatic test_full_table();
		logic [KEY_W-1:0] keys[$];
		for (int i = 0; i < CAPACITY; i++) begin
			keys.push_back(rand_key(8'($urandom_range(0, 7))));
			add_key(keys[i], $urandom);
		end
		add_key(rand_key(8'h03), 32'h5);   // rejected
		add_key(keys[0], 32'h7);           // existing key still accumulates
		add_key(keys[CAPACITY-1], 32'hFFFF_FFFF);
		add_key(rand_key(8'hFF), 32'h1);   // rejected
		drain();                           // sender holds off until all rows are in
		report_all();
	endtask

	task automatic test_random();
		logic [KEY_W-1:0] k;
		for (int i = 0; i < 400; i++) begin
			no_gaps = (i / 60) % 3 == 1;
			if ($urandom_range(0, 24) == 0) begin
				report_all();
				key_pool.delete();
			end else begin
				if (key_pool.size() != 0 && $urandom_range(0, 9) < 5)
					k = key_pool[$urandom_range(0, key_pool.size() - 1)];
				else begin
					k = rand_key(8'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom));
					key_pool.push_back(k);
				end
				add_key(k, $urandom_range(0, 3) == 0 ? 32'hFFFF_FFF0 | $urandom_range(0, 15)
				                                      : $urandom);
			end
		end
		report_all();
	endtask

	// result side: random stall before each word
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	always @(posedge clk) begin
		row_t r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_rows++;
			if (rows_due.size() == 0) begin
				$error("unexpected row: kind %0d data %h", m_axis_tuser, m_axis_tdata);
				errors++;
			end else begin
				r = rows_due.pop_front();
				if (m_axis_tuser !== r.kind) begin
					$error("row_kind: expected %0d, got %0d", r.kind, m_axis_tuser);
					errors++;
				end
				if (m_axis_tdata[7:0] !== r.data[7:0]) begin
					$error("out_first_byte: expected %h, got %h", r.data[7:0],
						m_axis_tdata[7:0]);
					errors++;
				end
				for (int w = 0; w < 8; w++)
					if (m_axis_tdata[8 + 64*w +: 64] !== r.data[8 + 64*w +: 64]) begin
						$error("out_rest_%0d: expected %h, got %h", w,
							r.data[8 + 64*w +: 64], m_axis_tdata[8 + 64*w +: 64]);
						errors++;
					end
				if (m_axis_tdata[ENT_W-1 -: SUM_W] !== r.data[ENT_W-1 -: SUM_W]) begin
					$error("sum_value: expected %h, got %h", r.data[ENT_W-1 -: SUM_W],
						m_axis_tdata[ENT_W-1 -: SUM_W]);
					errors++;
				end
				if (m_axis_tlast !== r.last) begin
					$error("last_row: expected %b, got %b", r.last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		tbl_count     = 0;
		errors        = 0;
		n_adds        = 0;
		n_reports     = 0;
		n_rejects     = 0;
		n_rows        = 0;
		no_gaps       = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_report();
		test_extremes();
		test_full_table();
		test_random();
		drain();
		if (rows_due.size() != 0) begin
			$error("%0d rows never arrived", rows_due.size());
			errors++;
		end
		$display("Covered %0d adds (%0d turned away on a full table), %0d reports,",
			n_adds, n_rejects, n_reports);
		$display("%0d rows checked, %0d mismatches", n_rows, errors);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire

FILE: per_key_amount_aggregator_top.f
+incdir+rtl
rtl/pkaa_pkg.sv
rtl/per_key_amount_aggregator_top.sv
dv/testbench.sv
